// ----- rtl/core/dmc_pkg.sv -----
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared types, codes and constants of the delta-modulation sample channel.
// ----------------------------------------------------------------------------
`default_nettype none

package dmc_pkg;

  // Request kinds carried by req_type.
  typedef enum logic [1:0] {
    REQ_WRITE  = 2'd0,
    REQ_TICK   = 2'd1,
    REQ_DMA    = 2'd2,
    REQ_ENABLE = 2'd3
  } req_kind_t;

  // Register selects carried by reg_offset.
  typedef enum logic [1:0] {
    REG_FLAGS   = 2'd0,
    REG_DIRECT  = 2'd1,
    REG_ADDRESS = 2'd2,
    REG_LENGTH  = 2'd3
  } reg_sel_t;

  localparam logic [15:0] ResetAddr   = 16'hC000;
  localparam logic [15:0] WrapAddr    = 16'h8000;
  localparam logic [15:0] LastAddr    = 16'hFFFF;
  localparam logic [6:0]  LevelUpMax  = 7'd125;
  localparam logic [6:0]  LevelDnMin  = 7'd2;
  localparam logic [3:0]  BitsPerByte = 4'd8;
  localparam logic [8:0]  PeriodMax   = 9'd428;
  localparam logic [11:0] LengthReset = 12'd1;

  // One request as it is held in the input register.
  typedef struct packed {
    req_kind_t  kind;
    reg_sel_t   sel;
    logic [7:0] write_data;
    logic [7:0] sample_byte;
    logic       channel_enable;
  } req_t;

  // One result as it is held in the result register.
  typedef struct packed {
    logic [6:0]  output_level;
    logic        dma_request;
    logic [15:0] fetch_address;
    logic        irq_pending;
    logic        playing;
  } res_t;

  // Timer periods, indexed by the rate field of the flags register.
  function automatic logic [8:0] rate_period(input logic [3:0] idx);
    logic [8:0] p;
    case (idx)
      4'd0:    p = 9'd428;
      4'd1:    p = 9'd380;
      4'd2:    p = 9'd340;
      4'd3:    p = 9'd320;
      4'd4:    p = 9'd286;
      4'd5:    p = 9'd254;
      4'd6:    p = 9'd226;
      4'd7:    p = 9'd214;
      4'd8:    p = 9'd190;
      4'd9:    p = 9'd160;
      4'd10:   p = 9'd142;
      4'd11:   p = 9'd128;
      4'd12:   p = 9'd106;
      4'd13:   p = 9'd84;
      4'd14:   p = 9'd72;
      default: p = 9'd54;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dmc_in_stage.sv -----
// ----------------------------------------------------------------------------
// dmc_in_stage
// Input register: holds one request until the channel core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dmc_in_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire dmc_pkg::req_t req_in,
  output logic               held_valid,
  output dmc_pkg::req_t      held_req,
  input  wire logic          take
);

  // Refill whenever the held beat leaves, or the register is empty.
  assign req_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (req_ready) begin
      held_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      held_req <= req_in;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/dmc_core.sv -----
// ----------------------------------------------------------------------------
// dmc_core
// Channel state and the combinational update for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module dmc_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          fire,
  input  wire dmc_pkg::req_t req,
  output dmc_pkg::res_t      res_next
);

  logic [8:0]  tick_counter, tick_counter_next;
  logic [8:0]  reload_period, reload_period_next;
  logic        irq_enable, irq_enable_next;
  logic        loop_mode, loop_mode_next;
  logic        irq_flag, irq_flag_next;
  logic [6:0]  level, level_next;
  logic [15:0] start_address, start_address_next;
  logic [11:0] length_bytes, length_bytes_next;
  logic [15:0] current_address, current_address_next;
  logic [11:0] bytes_left, bytes_left_next;
  logic [7:0]  shift_reg, shift_reg_next;
  logic [3:0]  bits_left, bits_left_next;
  logic [7:0]  buffer_byte, buffer_byte_next;
  logic        buffer_empty, buffer_empty_next;
  logic        silence, silence_next;

  logic        fetch_open;
  logic [11:0] bytes_dec;
  logic [3:0]  bits_dec;

  assign fetch_open = buffer_empty && (bytes_left != 12'd0);
  assign bytes_dec  = bytes_left - 12'd1;
  assign bits_dec   = bits_left - 4'd1;

  always_comb begin
    tick_counter_next    = tick_counter;
    reload_period_next   = reload_period;
    irq_enable_next      = irq_enable;
    loop_mode_next       = loop_mode;
    irq_flag_next        = irq_flag;
    level_next           = level;
    start_address_next   = start_address;
    length_bytes_next    = length_bytes;
    current_address_next = current_address;
    bytes_left_next      = bytes_left;
    shift_reg_next       = shift_reg;
    bits_left_next       = bits_left;
    buffer_byte_next     = buffer_byte;
    buffer_empty_next    = buffer_empty;
    silence_next         = silence;

    case (req.kind)
      dmc_pkg::REQ_WRITE: begin
        case (req.sel)
          dmc_pkg::REG_FLAGS: begin
            irq_enable_next    = req.write_data[7];
            loop_mode_next     = req.write_data[6];
            reload_period_next = dmc_pkg::rate_period(req.write_data[3:0]);
            if (!req.write_data[7]) begin
              irq_flag_next = 1'b0;
            end
          end
          dmc_pkg::REG_DIRECT: begin
            level_next = req.write_data[6:0];
          end
          dmc_pkg::REG_ADDRESS: begin
            start_address_next = dmc_pkg::ResetAddr + {2'b00, req.write_data, 6'b000000};
          end
          default: begin
            length_bytes_next = {req.write_data, 4'b0001};
          end
        endcase
      end

      dmc_pkg::REQ_TICK: begin
        if (tick_counter != 9'd0) begin
          tick_counter_next = tick_counter - 9'd1;
        end else begin
          tick_counter_next = reload_period;
          if (!silence) begin
            if (shift_reg[0]) begin
              if (level <= dmc_pkg::LevelUpMax) begin
                level_next = level + 7'd2;
              end
            end else if (level >= dmc_pkg::LevelDnMin) begin
              level_next = level - 7'd2;
            end
          end
          shift_reg_next = {1'b0, shift_reg[7:1]};
          bits_left_next = bits_dec;
          if (bits_dec == 4'd0) begin
            bits_left_next = dmc_pkg::BitsPerByte;
            if (buffer_empty) begin
              silence_next = 1'b1;
            end else begin
              silence_next      = 1'b0;
              shift_reg_next    = buffer_byte;
              buffer_empty_next = 1'b1;
            end
          end
        end
      end

      dmc_pkg::REQ_DMA: begin
        if (fetch_open) begin
          buffer_byte_next  = req.sample_byte;
          buffer_empty_next = 1'b0;
          if (current_address == dmc_pkg::LastAddr) begin
            current_address_next = dmc_pkg::WrapAddr;
          end else begin
            current_address_next = current_address + 16'd1;
          end
          bytes_left_next = bytes_dec;
          if (bytes_dec == 12'd0) begin
            if (loop_mode) begin
              current_address_next = start_address;
              bytes_left_next      = length_bytes;
            end else if (irq_enable) begin
              irq_flag_next = 1'b1;
            end
          end
        end
      end

      default: begin
        irq_flag_next = 1'b0;
        if (!req.channel_enable) begin
          bytes_left_next = 12'd0;
        end else if (bytes_left == 12'd0) begin
          current_address_next = start_address;
          bytes_left_next      = length_bytes;
        end
      end
    endcase
  end

  // The result shows the state as it stands after this request.
  always_comb begin
    res_next.output_level  = level_next;
    res_next.dma_request   = buffer_empty_next && (bytes_left_next != 12'd0);
    res_next.fetch_address = current_address_next;
    res_next.irq_pending   = irq_flag_next;
    res_next.playing       = bytes_left_next != 12'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter    <= 9'd0;
      reload_period   <= dmc_pkg::PeriodMax;
      irq_enable      <= 1'b0;
      loop_mode       <= 1'b0;
      irq_flag        <= 1'b0;
      level           <= 7'd0;
      start_address   <= dmc_pkg::ResetAddr;
      length_bytes    <= dmc_pkg::LengthReset;
      current_address <= dmc_pkg::ResetAddr;
      bytes_left      <= 12'd0;
      shift_reg       <= 8'd0;
      bits_left       <= dmc_pkg::BitsPerByte;
      buffer_byte     <= 8'd0;
      buffer_empty    <= 1'b1;
      silence         <= 1'b1;
    end else if (fire) begin
      tick_counter    <= tick_counter_next;
      reload_period   <= reload_period_next;
      irq_enable      <= irq_enable_next;
      loop_mode       <= loop_mode_next;
      irq_flag        <= irq_flag_next;
      level           <= level_next;
      start_address   <= start_address_next;
      length_bytes    <= length_bytes_next;
      current_address <= current_address_next;
      bytes_left      <= bytes_left_next;
      shift_reg       <= shift_reg_next;
      bits_left       <= bits_left_next;
      buffer_byte     <= buffer_byte_next;
      buffer_empty    <= buffer_empty_next;
      silence         <= silence_next;
    end
  end

  // The bit count runs from eight down to one and never sits at zero.
  a_bits_range: assert property (@(posedge clk) disable iff (rst)
    (bits_left != 4'd0) && (bits_left <= dmc_pkg::BitsPerByte))
    else $error("dmc_core: bit count out of range");

  // The timer never holds more than the longest period.
  a_tick_range: assert property (@(posedge clk) disable iff (rst)
    tick_counter <= dmc_pkg::PeriodMax)
    else $error("dmc_core: timer above longest period");

  // A requested byte always lands in the buffer.
  a_dma_fill: assert property (@(posedge clk) disable iff (rst)
    (fire && (req.kind == dmc_pkg::REQ_DMA) && fetch_open) |=> !buffer_empty)
    else $error("dmc_core: delivered byte did not fill the buffer");

  // Any enable request leaves the interrupt flag cleared.
  a_enable_clears_irq: assert property (@(posedge clk) disable iff (rst)
    (fire && (req.kind == dmc_pkg::REQ_ENABLE)) |=> !irq_flag)
    else $error("dmc_core: enable request left the interrupt flag set");

endmodule

`default_nettype wire

// ----- rtl/core/dmc_out_stage.sv -----
// ----------------------------------------------------------------------------
// dmc_out_stage
// Result register: holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dmc_out_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire dmc_pkg::res_t res_in,
  output logic               free,
  output logic               res_valid,
  input  wire logic          res_ready,
  output dmc_pkg::res_t      res
);

  // Space opens in the same cycle that the waiting beat is taken.
  assign free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (free) begin
      res_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_in;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/delta_modulation_sample_channel.sv -----
// ----------------------------------------------------------------------------
// delta_modulation_sample_channel
// Delta-modulation sample channel with DMA sample fetch and interrupt.
// ----------------------------------------------------------------------------
// Every request beat (register write, timer tick, DMA byte delivery or
// channel enable) produces exactly one result beat that shows the channel
// state after that request. The channel takes one request per clock cycle
// while the consumer keeps res_ready high. A request is captured in the
// input register when it is accepted, the whole state update is done by one
// pass of logic while it sits there, and the result register is loaded once
// it has room. Throughput is set by the single state update per cycle; the
// result register and the input register both pass a new beat in the cycle
// that the previous one leaves, so the block only stalls when the consumer
// holds res_ready low.
// ----------------------------------------------------------------------------
`default_nettype none

module delta_modulation_sample_channel (
  input  wire logic        clk,
  input  wire logic        rst,
  // Request channel.
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire logic [1:0]  req_type,
  input  wire logic [1:0]  reg_offset,
  input  wire logic [7:0]  write_data,
  input  wire logic [7:0]  sample_byte,
  input  wire logic        channel_enable,
  // Result channel.
  output logic             res_valid,
  input  wire logic        res_ready,
  output logic [6:0]       output_level,
  output logic             dma_request,
  output logic [15:0]      fetch_address,
  output logic             irq_pending,
  output logic             playing
);

  dmc_pkg::req_t req_in;
  dmc_pkg::req_t held_req;
  dmc_pkg::res_t res_next;
  dmc_pkg::res_t res;
  logic          held_valid;
  logic          out_free;
  logic          fire;

  // Pack the request fields. Codes that carry no meaning for a kind are
  // simply ignored by the core.
  always_comb begin
    req_in.kind           = dmc_pkg::req_kind_t'(req_type);
    req_in.sel            = dmc_pkg::reg_sel_t'(reg_offset);
    req_in.write_data     = write_data;
    req_in.sample_byte    = sample_byte;
    req_in.channel_enable = channel_enable;
  end

  // A held request is processed in the cycle the result register has room.
  assign fire = held_valid && out_free;

  dmc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req_in     (req_in),
    .held_valid (held_valid),
    .held_req   (held_req),
    .take       (fire)
  );

  dmc_core u_core (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .req      (held_req),
    .res_next (res_next)
  );

  dmc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .res_in    (res_next),
    .free      (out_free),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign output_level  = res.output_level;
  assign dma_request   = res.dma_request;
  assign fetch_address = res.fetch_address;
  assign irq_pending   = res.irq_pending;
  assign playing       = res.playing;

endmodule

`default_nettype wire
